[rtl/wsdf_pkg.sv]
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and codes of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  localparam int unsigned LenW = 63;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;

  // close reasons
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PROTOCOL = 2'd1;
  localparam logic [1:0] ERR_TOO_BIG  = 2'd2;

  // header field constants
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [7:0] RSV_MASK    = 8'h70;
  localparam int unsigned HdrMax     = 14;
  localparam logic [LenW-1:0] MAX_FRAME_RESET = 63'd1048576;

  typedef struct packed {
    logic [1:0]      item_kind;
    logic [7:0]      payload_byte;
    logic            frame_start;
    logic            frame_end;
    logic            fin_flag;
    logic [3:0]      frame_opcode;
    logic            is_control;
    logic [LenW-1:0] payload_length;
    logic [1:0]      error_code;
  } result_t;

endpackage

[rtl/wsdf_in_if.sv]
// ----------------------------------------------------------------------------
// wsdf_in_if
// Byte stream channel into the deframer.
// ----------------------------------------------------------------------------
interface wsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

[rtl/wsdf_out_if.sv]
// ----------------------------------------------------------------------------
// wsdf_out_if
// Result channel out of the deframer.
// ----------------------------------------------------------------------------
interface wsdf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [7:0]  payload_byte;
  logic        frame_start;
  logic        frame_end;
  logic        fin_flag;
  logic [3:0]  frame_opcode;
  logic        is_control;
  logic [62:0] payload_length;
  logic [1:0]  error_code;

  modport source (output valid, output item_kind, output payload_byte,
                  output frame_start, output frame_end, output fin_flag,
                  output frame_opcode, output is_control, output payload_length,
                  output error_code, input ready);
  modport sink (input valid, input item_kind, input payload_byte,
                input frame_start, input frame_end, input fin_flag,
                input frame_opcode, input is_control, input payload_length,
                input error_code, output ready);
endinterface

[rtl/wsdf_front.sv]
// ----------------------------------------------------------------------------
// wsdf_front
// Header collection and checks, payload unmasking; one byte a cycle on accept.
// ----------------------------------------------------------------------------
module wsdf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wsdf_pkg::LenW-1:0]     cfg_data,
  input  logic                          accept,
  input  logic [7:0]                    data_byte,
  output wsdf_pkg::result_t             result
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_ERROR   = 2'd2;

  logic [1:0]                  phase;
  logic [7:0]                  header_store [wsdf_pkg::HdrMax];
  logic [3:0]                  hdr_fill;
  logic                        current_fin;
  logic [3:0]                  current_opcode;
  logic [31:0]                 mask_key;
  logic [wsdf_pkg::LenW-1:0]   declared_bytes;
  logic [wsdf_pkg::LenW-1:0]   remaining;
  logic [1:0]                  key_idx;
  logic [1:0]                  error_latched;
  logic [wsdf_pkg::LenW-1:0]   size_limit;

  logic [7:0]  hdr_v [wsdf_pkg::HdrMax];
  logic [3:0]  count_inc;
  logic [3:0]  needed;
  logic        complete;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [63:0] len_sel;
  logic [1:0]  hdr_err;
  logic [31:0] key_sel;
  logic [7:0]  key_byte;
  logic        last_payload;

  // header view with the current byte in place
  always_comb begin
    for (int i = 0; i < wsdf_pkg::HdrMax; i++) begin
      hdr_v[i] = (hdr_fill == 4'(i)) ? data_byte : header_store[i];
    end
  end

  assign b0        = hdr_v[0];
  assign b1        = hdr_v[1];
  assign count_inc = hdr_fill + 4'd1;

  // header length and completion
  always_comb begin
    needed = 4'd2;
    if (b1[6:0] == wsdf_pkg::LEN_CODE_16) begin
      needed = 4'd4;
    end else if (b1[6:0] == wsdf_pkg::LEN_CODE_64) begin
      needed = 4'd10;
    end
    if (b1[7]) begin
      needed = needed + 4'd4;
    end
    complete = (count_inc >= 4'd2) && (count_inc >= needed);
  end

  // length, mask key and checks
  always_comb begin
    len_sel = {57'd0, b1[6:0]};
    key_sel = {hdr_v[2], hdr_v[3], hdr_v[4], hdr_v[5]};
    if (b1[6:0] == wsdf_pkg::LEN_CODE_16) begin
      len_sel = {48'd0, hdr_v[2], hdr_v[3]};
      key_sel = {hdr_v[4], hdr_v[5], hdr_v[6], hdr_v[7]};
    end else if (b1[6:0] == wsdf_pkg::LEN_CODE_64) begin
      len_sel = {hdr_v[2], hdr_v[3], hdr_v[4], hdr_v[5],
                 hdr_v[6], hdr_v[7], hdr_v[8], hdr_v[9]};
      key_sel = {hdr_v[10], hdr_v[11], hdr_v[12], hdr_v[13]};
    end
    hdr_err = wsdf_pkg::ERR_NONE;
    if ((b0 & wsdf_pkg::RSV_MASK) != 8'd0) begin
      hdr_err = wsdf_pkg::ERR_PROTOCOL;
    end else if (!b1[7]) begin
      hdr_err = wsdf_pkg::ERR_PROTOCOL;
    end else if (len_sel[63]) begin
      hdr_err = wsdf_pkg::ERR_TOO_BIG;
    end else if (len_sel[62:0] > size_limit) begin
      hdr_err = wsdf_pkg::ERR_TOO_BIG;
    end
  end

  // rotating mask byte
  always_comb begin
    case (key_idx)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign last_payload = (remaining == {{(wsdf_pkg::LenW-1){1'b0}}, 1'b1});

  // result of the byte at hand
  always_comb begin
    result                = '0;
    result.fin_flag       = current_fin;
    result.frame_opcode   = current_opcode;
    result.is_control     = current_opcode[3];
    result.payload_length = declared_bytes;
    result.error_code     = error_latched;
    case (phase)
      PH_ERROR: begin
        result.item_kind = wsdf_pkg::KIND_DISCARD;
      end
      PH_PAYLOAD: begin
        result.item_kind    = wsdf_pkg::KIND_PAYLOAD;
        result.payload_byte = data_byte ^ key_byte;
        result.frame_end    = last_payload;
      end
      default: begin
        result.item_kind = wsdf_pkg::KIND_HEADER;
        if (complete) begin
          result.fin_flag     = b0[7];
          result.frame_opcode = b0[3:0];
          result.is_control   = b0[3];
          if (hdr_err != wsdf_pkg::ERR_NONE) begin
            result.error_code = hdr_err;
          end else begin
            result.frame_start    = 1'b1;
            result.payload_length = len_sel[62:0];
            result.frame_end      = (len_sel == 64'd0);
          end
        end
      end
    endcase
  end

  // header bytes
  always_ff @(posedge clk) begin
    if (accept && phase == PH_HEADER && hdr_fill < 4'(wsdf_pkg::HdrMax)) begin
      header_store[hdr_fill] <= data_byte;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= wsdf_pkg::MAX_FRAME_RESET;
    end else if (cfg_we) begin
      size_limit <= cfg_data;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      hdr_fill       <= 4'd0;
      current_fin    <= 1'b0;
      current_opcode <= 4'd0;
      mask_key       <= 32'd0;
      declared_bytes <= '0;
      remaining      <= '0;
      key_idx        <= 2'd0;
      error_latched  <= wsdf_pkg::ERR_NONE;
    end else if (accept) begin
      case (phase)
        PH_PAYLOAD: begin
          if (last_payload) begin
            phase          <= PH_HEADER;
            hdr_fill       <= 4'd0;
            current_fin    <= 1'b0;
            current_opcode <= 4'd0;
            declared_bytes <= '0;
            remaining      <= '0;
          end else begin
            remaining <= remaining - 1'b1;
            key_idx   <= key_idx + 2'd1;
          end
        end
        PH_HEADER: begin
          hdr_fill <= count_inc;
          if (complete) begin
            current_fin    <= b0[7];
            current_opcode <= b0[3:0];
            if (hdr_err != wsdf_pkg::ERR_NONE) begin
              error_latched <= hdr_err;
              phase         <= PH_ERROR;
            end else if (len_sel == 64'd0) begin
              mask_key       <= key_sel;
              hdr_fill       <= 4'd0;
              current_fin    <= 1'b0;
              current_opcode <= 4'd0;
            end else begin
              mask_key       <= key_sel;
              declared_bytes <= len_sel[62:0];
              remaining      <= len_sel[62:0];
              key_idx        <= 2'd0;
              phase          <= PH_PAYLOAD;
            end
          end
        end
        default: begin
          phase <= PH_ERROR;
        end
      endcase
    end
  end

endmodule

[rtl/wsdf_queue.sv]
// ----------------------------------------------------------------------------
// wsdf_queue
// Short result queue; its head drives the result channel.
// ----------------------------------------------------------------------------
module wsdf_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsdf_pkg::result_t push_data,
  output logic              has_room,
  wsdf_out_if.source        tx
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wsdf_pkg::result_t mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              pop;
  wsdf_pkg::result_t head;

  assign has_room = (count != CntW'(Depth));
  assign pop      = tx.valid && tx.ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // head beat
  assign head              = mem[rd_ptr];
  assign tx.valid          = (count != '0);
  assign tx.item_kind      = head.item_kind;
  assign tx.payload_byte   = head.payload_byte;
  assign tx.frame_start    = head.frame_start;
  assign tx.frame_end      = head.frame_end;
  assign tx.fin_flag       = head.fin_flag;
  assign tx.frame_opcode   = head.frame_opcode;
  assign tx.is_control     = head.is_control;
  assign tx.payload_length = head.payload_length;
  assign tx.error_code     = head.error_code;

endmodule

[rtl/websocket_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Server-side websocket frame deframer: header parse, checks and unmasking.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  rx      | in  | one received byte of the frame stream
//  tx      | out | one result per received byte
//  cfg     | in  | frame size limit write, no read-back
//
//  one byte is taken per cycle while the result queue has room; its result
//  is queued the same edge and can leave the next cycle, so throughput is
//  one beat per cycle, set by the header/payload state update.
//  rst is synchronous and clears the frame state, the error and the queue.
//  rx stalls only when the result queue (QueueDepth beats) is full.
module websocket_frame_deframer_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [62:0] cfg_data,
  wsdf_in_if.sink     rx,
  wsdf_out_if.source  tx
);

  logic              accept;
  logic              has_room;
  wsdf_pkg::result_t result;

  assign rx.ready = has_room;
  assign accept   = rx.valid && has_room;

  // front: parse and unmask
  wsdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (rx.data_byte),
    .result    (result)
  );

  // back: result queue
  wsdf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .has_room  (has_room),
    .tx        (tx)
  );

  // a payload or frame start beat never carries an error
  assert property (@(posedge clk) disable iff (rst)
    tx.valid && (tx.item_kind == wsdf_pkg::KIND_PAYLOAD || tx.frame_start)
    |-> tx.error_code == wsdf_pkg::ERR_NONE)
    else $error("payload beat with error code");

  // a stalled input means results are waiting
  assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> tx.valid)
    else $error("input stalled with empty queue");

  // a discard beat always reports the latched error
  assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.item_kind == wsdf_pkg::KIND_DISCARD
    |-> tx.error_code != wsdf_pkg::ERR_NONE)
    else $error("discard beat without error");

endmodule

[tb/websocket_frame_deframer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit_tb
// Drives masked websocket frames byte by byte into the deframer under random
// sender bursts and receiver stalls. Every result is checked against an
// in-bench deframer model: a short directed table first, then random frames
// over several frame size limits, and one closing bad frame. Errors
// are sticky until reset, so the bad frame comes last.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit_tb;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } deframe_phase_e;

  typedef enum int {
    BAD_RESERVED = 0,
    BAD_UNMASKED = 1,
    BAD_TOP_BIT  = 2,
    BAD_OVER_MAX = 3
  } bad_frame_e;

  typedef struct {
    logic [7:0] data;
    bit         known;
    logic [1:0] kind;
  } stim_row_t;

  localparam logic [62:0] MaxLen63 = {63{1'b1}};
  localparam logic [62:0] ResetMax = 63'd1048576;
  localparam int unsigned TargetBytes = 1700;
  localparam logic [1:0] KH = wsdf_pkg::KIND_HEADER;
  localparam logic [1:0] KP = wsdf_pkg::KIND_PAYLOAD;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [62:0] cfg_data;

  wsdf_in_if rx_if ();
  wsdf_out_if tx_if ();

  websocket_frame_deframer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rx       (rx_if.sink),
    .tx       (tx_if.source)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // model state
  deframe_phase_e m_phase;
  logic [7:0]  m_hdr [wsdf_pkg::HdrMax];
  int unsigned m_hdr_count;
  int unsigned m_hdr_needed;
  logic        m_fin;
  logic [3:0]  m_opcode;
  logic [31:0] m_key;
  logic [63:0] m_declared;
  logic [63:0] m_received;
  logic [1:0]  m_err;
  logic [62:0] m_max_size;

  wsdf_pkg::result_t expected_results[$];
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned burst_left;
  stim_row_t   table_rows[$];
  stim_row_t   cur_row;
  bit          row_known;

  // clear per-frame state
  task automatic close_frame();
    m_phase = PH_HEADER;
    m_hdr_count = 0;
    m_hdr_needed = 2;
    m_fin = 1'b0;
    m_opcode = 4'd0;
    m_declared = 64'd0;
    m_received = 64'd0;
  endtask

  function automatic int unsigned header_length(input logic [7:0] b1);
    int unsigned n;
    n = 2;
    if (b1[6:0] == wsdf_pkg::LEN_CODE_16) n += 2;
    else if (b1[6:0] == wsdf_pkg::LEN_CODE_64) n += 8;
    if (b1[7]) n += 4;
    return n;
  endfunction

  // work out the result of one accepted byte
  task automatic deframe_byte(input logic [7:0] b, output wsdf_pkg::result_t r);
    logic [7:0]  key_byte;
    logic [63:0] len;
    logic [1:0]  err;
    int unsigned off;
    bit          closing;
    r = '0;
    closing = 0;
    if (m_phase == PH_ERROR) begin
      r.item_kind = wsdf_pkg::KIND_DISCARD;
    end else if (m_phase == PH_PAYLOAD) begin
      key_byte = m_key[31 - 8 * m_received[1:0] -: 8];
      r.item_kind = wsdf_pkg::KIND_PAYLOAD;
      r.payload_byte = b ^ key_byte;
      m_received++;
      if (m_received >= m_declared) begin
        r.frame_end = 1'b1;
        closing = 1;
      end
    end else begin
      r.item_kind = wsdf_pkg::KIND_HEADER;
      m_hdr[m_hdr_count] = b;
      m_hdr_count++;
      if (m_hdr_count >= 2) m_hdr_needed = header_length(m_hdr[1]);
      if (m_hdr_count >= 2 && m_hdr_count >= m_hdr_needed) begin
        len = {57'd0, m_hdr[1][6:0]};
        off = 2;
        err = wsdf_pkg::ERR_NONE;
        m_fin = m_hdr[0][7];
        m_opcode = m_hdr[0][3:0];
        if ((m_hdr[0] & wsdf_pkg::RSV_MASK) != 8'd0 || !m_hdr[1][7]) begin
          err = wsdf_pkg::ERR_PROTOCOL;
        end else begin
          if (m_hdr[1][6:0] == wsdf_pkg::LEN_CODE_16) begin
            len = {48'd0, m_hdr[2], m_hdr[3]};
            off = 4;
          end else if (m_hdr[1][6:0] == wsdf_pkg::LEN_CODE_64) begin
            len = {m_hdr[2], m_hdr[3], m_hdr[4], m_hdr[5],
                   m_hdr[6], m_hdr[7], m_hdr[8], m_hdr[9]};
            off = 10;
            if (len[63]) err = wsdf_pkg::ERR_TOO_BIG;
          end
          if (err == wsdf_pkg::ERR_NONE && len > {1'b0, m_max_size}) begin
            err = wsdf_pkg::ERR_TOO_BIG;
          end
        end
        if (err != wsdf_pkg::ERR_NONE) begin
          m_err = err;
          m_phase = PH_ERROR;
        end else begin
          m_key = {m_hdr[off], m_hdr[off + 1], m_hdr[off + 2], m_hdr[off + 3]};
          m_declared = len;
          m_received = 64'd0;
          r.frame_start = 1'b1;
          if (len == 64'd0) begin
            r.frame_end = 1'b1;
            closing = 1;
          end else begin
            m_phase = PH_PAYLOAD;
          end
        end
      end
    end
    r.fin_flag = m_fin;
    r.frame_opcode = m_opcode;
    r.is_control = m_opcode[3];
    r.payload_length = m_declared[62:0];
    r.error_code = m_err;
    if (closing) close_frame();
  endtask

  // send one byte in bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    wsdf_pkg::result_t r;
    if (burst_left == 0) begin
      @(negedge clk);
      rx_if.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 4) == 0 ? 200 : $urandom_range(1, 12);
    end
    @(negedge clk);
    rx_if.valid = 1'b1;
    rx_if.data_byte = b;
    do @(posedge clk); while (!rx_if.ready);
    deframe_byte(b, r);
    if (row_known) begin
      r.item_kind = cur_row.kind;
    end
    expected_results.push_back(r);
    burst_left--;
    bytes_sent++;
  endtask

  // pause until the block has drained
  task automatic wait_drained();
    @(negedge clk);
    rx_if.valid = 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_size(input logic [62:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(posedge clk);
    m_max_size = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_header(input logic [7:0] b0, input logic [63:0] len,
                             input int unsigned code_sel, input bit masked);
    logic [7:0] b1;
    logic [31:0] key;
    b1 = code_sel == 0 ? {1'b0, len[6:0]} :
         code_sel == 1 ? {1'b0, wsdf_pkg::LEN_CODE_16} : {1'b0, wsdf_pkg::LEN_CODE_64};
    b1[7] = masked;
    send_byte(b0);
    send_byte(b1);
    if (code_sel == 1) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (code_sel == 2) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    key = $urandom;
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
  endtask

  // one well-formed masked frame with random content
  task automatic send_frame(input logic [62:0] cap);
    logic [7:0]  b0;
    logic [63:0] len;
    int unsigned pick;
    int unsigned code_sel;
    pick = $urandom_range(0, 99);
    len = pick < 10 ? 64'd0 : pick < 95 ? 64'($urandom_range(1, 20))
                                         : 64'($urandom_range(21, 300));
    if (len > {1'b0, cap}) len = 64'($urandom_range(0, int'(cap)));
    b0 = 8'($urandom);
    b0[6:4] = 3'b000;
    code_sel = $urandom_range(0, 2);
    if (len > 125 && code_sel == 0) code_sel = 1;
    send_header(b0, len, code_sel, 1'b1);
    for (int i = 0; i < int'(len); i++) send_byte(8'($urandom));
  endtask

  // result check
  always @(posedge clk) begin
    wsdf_pkg::result_t exp_r;
    if (!rst && tx_if.valid && tx_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat, kind %0d", tx_if.item_kind);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (tx_if.item_kind !== exp_r.item_kind) begin
          $error("item_kind exp %0d got %0d", exp_r.item_kind, tx_if.item_kind);
          fail_count++;
        end
        if (tx_if.payload_byte !== exp_r.payload_byte) begin
          $error("payload_byte exp %0h got %0h", exp_r.payload_byte, tx_if.payload_byte);
          fail_count++;
        end
        if (tx_if.frame_start !== exp_r.frame_start) begin
          $error("frame_start exp %0d got %0d", exp_r.frame_start, tx_if.frame_start);
          fail_count++;
        end
        if (tx_if.frame_end !== exp_r.frame_end) begin
          $error("frame_end exp %0d got %0d", exp_r.frame_end, tx_if.frame_end);
          fail_count++;
        end
        if (tx_if.fin_flag !== exp_r.fin_flag) begin
          $error("fin_flag exp %0d got %0d", exp_r.fin_flag, tx_if.fin_flag);
          fail_count++;
        end
        if (tx_if.frame_opcode !== exp_r.frame_opcode) begin
          $error("frame_opcode exp %0h got %0h", exp_r.frame_opcode, tx_if.frame_opcode);
          fail_count++;
        end
        if (tx_if.is_control !== exp_r.is_control) begin
          $error("is_control exp %0d got %0d", exp_r.is_control, tx_if.is_control);
          fail_count++;
        end
        if (tx_if.payload_length !== exp_r.payload_length) begin
          $error("payload_length exp %0d got %0d", exp_r.payload_length,
                 tx_if.payload_length);
          fail_count++;
        end
        if (tx_if.error_code !== exp_r.error_code) begin
          $error("error_code exp %0d got %0d", exp_r.error_code, tx_if.error_code);
          fail_count++;
        end
      end
    end
  end

  // receiver stall pattern: open stretches, random stalls, periodic stalls
  int unsigned stall_mode;
  int unsigned stall_left;
  int unsigned stall_tick;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: begin
        tx_if.ready <= 1'b1;
      end
      1: begin
        tx_if.ready <= $urandom_range(0, 2) != 0;
      end
      default: begin
        tx_if.ready <= (stall_tick % 5) < 2;
      end
    endcase
  end

  // overall time limit
  initial begin
    #20ms;
    $display("websocket_frame_deframer_unit_tb: done, errors");
    $finish;
  end

  // stimulus
  initial begin
    logic [62:0] settings[5];
    logic [62:0] cap;
    bad_frame_e  bad;
    logic [7:0]  b0;
    int unsigned quota;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    rx_if.valid = 1'b0;
    rx_if.data_byte = 8'd0;
    tx_if.ready = 1'b0;
    stall_left = 0;
    stall_tick = 0;
    fail_count = 0;
    bytes_sent = 0;
    burst_left = 0;
    row_known = 0;
    m_max_size = ResetMax;
    m_key = 32'd0;
    m_err = wsdf_pkg::ERR_NONE;
    close_frame();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: ping, binary with 16-bit length, fin continuation
    table_rows = '{
      '{8'h89, 1, KH}, '{8'h80, 0, KH}, '{8'h11, 0, KH},
      '{8'h22, 0, KH}, '{8'h33, 0, KH}, '{8'h44, 1, KH},
      '{8'h02, 1, KH}, '{8'hFE, 0, KH}, '{8'h00, 0, KH},
      '{8'h02, 0, KH}, '{8'hA5, 0, KH}, '{8'h5A, 0, KH},
      '{8'hFF, 0, KH}, '{8'h00, 0, KH}, '{8'h00, 1, KP},
      '{8'hFF, 1, KP}, '{8'h80, 0, KH}, '{8'h81, 0, KH},
      '{8'h00, 0, KH}, '{8'h00, 0, KH}, '{8'h00, 0, KH},
      '{8'h00, 0, KH}, '{8'h7F, 1, KP}
    };
    foreach (table_rows[i]) begin
      cur_row = table_rows[i];
      row_known = cur_row.known;
      send_byte(cur_row.data);
    end
    row_known = 0;

    // random frames over several size limits, extremes included
    settings = '{63'd0, MaxLen63, 63'($urandom_range(1, 40)),
                 {23'd0, 8'($urandom), 32'($urandom)}, ResetMax};
    foreach (settings[s]) begin
      wait_drained();
      write_max_size(settings[s]);
      cap = settings[s] > 63'd300 ? 63'd300 : settings[s];
      quota = bytes_sent + TargetBytes / 5;
      while (bytes_sent < quota) begin
        send_frame(cap);
        if ($urandom_range(0, 30) == 0) wait_drained();
      end
    end

    // closing bad frame, then bytes that must be discarded
    wait_drained();
    write_max_size(63'($urandom_range(0, 200)));
    bad = bad_frame_e'($urandom_range(0, 3));
    b0 = 8'($urandom);
    b0[6:4] = 3'b000;
    case (bad)
      BAD_RESERVED: begin
        b0[6:4] = 3'($urandom_range(1, 7));
        send_header(b0, 64'd3, 0, 1'b1);
      end
      BAD_UNMASKED: send_header(b0, 64'($urandom_range(0, 125)), 0, 1'b0);
      BAD_TOP_BIT:  send_header(b0, {1'b1, 31'($urandom), 32'($urandom)}, 2, 1'b1);
      default:      send_header(b0, {1'b0, m_max_size} + 64'd1, 1, 1'b1);
    endcase
    repeat (20) send_byte(8'($urandom));

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("websocket_frame_deframer_unit_tb: done, clean");
    end else begin
      $display("websocket_frame_deframer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/wsdf_pkg.sv
rtl/wsdf_in_if.sv
rtl/wsdf_out_if.sv
rtl/wsdf_front.sv
rtl/wsdf_queue.sv
rtl/websocket_frame_deframer_unit.sv
tb/websocket_frame_deframer_unit_tb.sv
